// ===== rtl/core/ecsr_pkg.sv =====
package ecsr_pkg;

    localparam int MaxRegions = 256;
    localparam int MaxEdges   = 1024;

    localparam int OpW   = 3;
    localparam int SrcW  = 8;
    localparam int IdxW  = 11;
    localparam int ValW  = 11;
    localparam int StatW = 3;
    localparam int RcW   = 9;

    localparam int RegW  = $clog2(MaxRegions);
    localparam int EdgeW = $clog2(MaxEdges);
    localparam int CntW  = $clog2(MaxEdges + 1);
    localparam int RegNW = $clog2(MaxRegions + 1);
    localparam int SeqW  = (CntW > RegNW) ? CntW : RegNW;

    typedef enum logic [OpW-1:0] {
        OP_CLEAR     = 3'd0,
        OP_APPEND    = 3'd1,
        OP_BUILD     = 3'd2,
        OP_READ_OFF  = 3'd3,
        OP_READ_SLOT = 3'd4
    } t_opcode;

    typedef enum logic [StatW-1:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_REGION = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_BAD_INDEX  = 3'd3,
        STAT_NOT_BUILT  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_COUNT,
        S_PREFIX,
        S_SCATTER
    } t_state;

endpackage

// ===== rtl/core/ecsr_if.sv =====
interface ecsr_in_if;
    logic                        valid;
    logic                        ready;
    logic [ecsr_pkg::OpW-1:0]    opcode;
    logic [ecsr_pkg::SrcW-1:0]   source_region;
    logic [ecsr_pkg::IdxW-1:0]   read_index;

    modport source (output valid, output opcode, output source_region, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input source_region, input read_index,
                    output ready);
endinterface

interface ecsr_out_if;
    logic                        valid;
    logic                        ready;
    logic [ecsr_pkg::ValW-1:0]   read_value;
    logic [ecsr_pkg::StatW-1:0]  status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

interface ecsr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ecsr_pkg::RcW-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ecsr_ram.sv =====
module ecsr_ram #(
    parameter int Depth = 256,
    parameter int Width = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/edge_list_to_csr_builder_top.sv =====
// Clear, append, unused opcodes and register-answered reads respond at the accepting edge;
// memory reads respond in the cycle after that. One item is taken per cycle at best.
// Build walks the cursor memory in clear, count, prefix and scatter phases: clear covers
// MAX_REGIONS entries, count and scatter walk the edge list, prefix the effective regions.
// Reset empties the edge list, drops the index and sets region_count to 256; the memories
// need no clearing pass, since build rewrites every entry that a read can reach.
module edge_list_to_csr_builder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ecsr_in_if.sink    i_cmd,
    ecsr_out_if.source o_rsp,
    ecsr_cfg_if.sink   i_cfg
);

    ecsr_pkg::t_state r_state, n_state;

    logic [ecsr_pkg::RcW-1:0]   r_rc;
    logic [ecsr_pkg::CntW-1:0]  r_edge_total, n_edge_total;
    logic                       r_valid, n_valid;
    logic [ecsr_pkg::CntW-1:0]  r_placed, n_placed;
    logic [ecsr_pkg::CntW-1:0]  r_acc, n_acc;
    logic [ecsr_pkg::SeqW-1:0]  r_seq, n_seq;
    logic                       r_rd_slot, n_rd_slot;

    logic                        r_p1_v, n_p1_v;
    logic [ecsr_pkg::EdgeW-1:0]  r_p1_edge, n_p1_edge;
    logic [ecsr_pkg::RegW-1:0]   r_p1_reg, n_p1_reg;
    logic                        r_p2_v, n_p2_v;
    logic [ecsr_pkg::EdgeW-1:0]  r_p2_edge, n_p2_edge;
    logic [ecsr_pkg::RegW-1:0]   r_p2_src, n_p2_src;
    logic                        r_fw_v, n_fw_v;
    logic [ecsr_pkg::RegW-1:0]   r_fw_addr, n_fw_addr;
    logic [ecsr_pkg::CntW-1:0]   r_fw_data, n_fw_data;

    logic                        r_out_v, n_out_v;
    logic [ecsr_pkg::ValW-1:0]   r_out_value, n_out_value;
    logic [ecsr_pkg::StatW-1:0]  r_out_status, n_out_status;

    logic [ecsr_pkg::RcW-1:0]    nreg;
    logic                        cmd_ready;
    logic                        cmd_take;
    logic                        cfg_take;
    logic                        issue;
    logic [ecsr_pkg::CntW-1:0]   cur;

    logic                        edge_we;
    logic [ecsr_pkg::SrcW-1:0]   q_src;
    logic                        offs_we;
    logic [ecsr_pkg::CntW-1:0]   q_offs;
    logic                        ord_we;
    logic [ecsr_pkg::EdgeW-1:0]  ord_waddr;
    logic [ecsr_pkg::EdgeW-1:0]  q_ord;
    logic                        cur_we;
    logic [ecsr_pkg::RegW-1:0]   cur_waddr;
    logic [ecsr_pkg::CntW-1:0]   cur_wdata;
    logic [ecsr_pkg::RegW-1:0]   cur_raddr;
    logic [ecsr_pkg::CntW-1:0]   q_cur;

    assign nreg = (r_rc > ecsr_pkg::RcW'(ecsr_pkg::MaxRegions))
                ? ecsr_pkg::RcW'(ecsr_pkg::MaxRegions) : r_rc;

    assign cmd_ready   = (r_state == ecsr_pkg::S_IDLE) && (!r_out_v || o_rsp.ready);
    assign i_cmd.ready = cmd_ready;
    assign cmd_take    = i_cmd.valid && cmd_ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_take    = i_cfg.valid;

    assign o_rsp.valid      = r_out_v;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.status     = r_out_status;

    ecsr_ram #(.Depth(ecsr_pkg::MaxEdges), .Width(ecsr_pkg::SrcW)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_edge_total[ecsr_pkg::EdgeW-1:0]),
        .i_wdata (i_cmd.source_region),
        .i_raddr (r_seq[ecsr_pkg::EdgeW-1:0]),
        .o_rdata (q_src)
    );

    ecsr_ram #(.Depth(ecsr_pkg::MaxRegions), .Width(ecsr_pkg::CntW)) u_offs_ram (
        .i_clk   (i_clk),
        .i_we    (offs_we),
        .i_waddr (r_p1_reg),
        .i_wdata (r_acc),
        .i_raddr (i_cmd.read_index[ecsr_pkg::RegW-1:0]),
        .o_rdata (q_offs)
    );

    ecsr_ram #(.Depth(ecsr_pkg::MaxEdges), .Width(ecsr_pkg::EdgeW)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (r_p2_edge),
        .i_raddr (i_cmd.read_index[ecsr_pkg::EdgeW-1:0]),
        .o_rdata (q_ord)
    );

    ecsr_ram #(.Depth(ecsr_pkg::MaxRegions), .Width(ecsr_pkg::CntW)) u_cursor_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_raddr (cur_raddr),
        .o_rdata (q_cur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ecsr_pkg::S_IDLE;
            r_rc         <= ecsr_pkg::RcW'(256);
            r_edge_total <= '0;
            r_valid      <= 1'b0;
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_fw_v       <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edge_total <= n_edge_total;
            r_p1_v       <= n_p1_v;
            r_p2_v       <= n_p2_v;
            r_fw_v       <= n_fw_v;
            r_out_v      <= n_out_v;
            if (cfg_take) begin
                r_rc    <= i_cfg.data;
                r_valid <= 1'b0;
            end else begin
                r_valid <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_placed     <= n_placed;
        r_acc        <= n_acc;
        r_seq        <= n_seq;
        r_rd_slot    <= n_rd_slot;
        r_p1_edge    <= n_p1_edge;
        r_p1_reg     <= n_p1_reg;
        r_p2_edge    <= n_p2_edge;
        r_p2_src     <= n_p2_src;
        r_fw_addr    <= n_fw_addr;
        r_fw_data    <= n_fw_data;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_edge_total = r_edge_total;
        n_valid      = r_valid;
        n_placed     = r_placed;
        n_acc        = r_acc;
        n_seq        = r_seq;
        n_rd_slot    = r_rd_slot;
        n_p1_v       = 1'b0;
        n_p1_edge    = r_seq[ecsr_pkg::EdgeW-1:0];
        n_p1_reg     = r_seq[ecsr_pkg::RegW-1:0];
        n_p2_v       = 1'b0;
        n_p2_edge    = r_p1_edge;
        n_p2_src     = q_src[ecsr_pkg::RegW-1:0];
        n_fw_v       = 1'b0;
        n_fw_addr    = r_p2_src;
        n_fw_data    = r_fw_data;
        n_out_v      = r_out_v && !o_rsp.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        edge_we   = 1'b0;
        offs_we   = 1'b0;
        ord_we    = 1'b0;
        cur_we    = 1'b0;
        cur_waddr = r_p2_src;
        cur_wdata = '0;
        cur_raddr = q_src[ecsr_pkg::RegW-1:0];
        issue     = 1'b0;
        cur       = (r_fw_v && (r_fw_addr == r_p2_src)) ? r_fw_data : q_cur;
        ord_waddr = cur[ecsr_pkg::EdgeW-1:0];

        unique case (r_state) inside
            ecsr_pkg::S_IDLE: begin
                if (cmd_take) begin
                    n_out_v      = 1'b1;
                    n_out_value  = '0;
                    n_out_status = ecsr_pkg::STAT_OK;
                    n_seq        = '0;
                    unique case (i_cmd.opcode)
                        ecsr_pkg::OP_CLEAR: begin
                            n_edge_total = '0;
                            n_valid      = 1'b0;
                        end
                        ecsr_pkg::OP_APPEND: begin
                            if (ecsr_pkg::RcW'(i_cmd.source_region) >= nreg) begin
                                n_out_status = ecsr_pkg::STAT_BAD_REGION;
                            end else if (r_edge_total >=
                                         ecsr_pkg::CntW'(ecsr_pkg::MaxEdges)) begin
                                n_out_status = ecsr_pkg::STAT_FULL;
                            end else begin
                                edge_we      = 1'b1;
                                n_edge_total = r_edge_total + 1'b1;
                                n_valid      = 1'b0;
                            end
                        end
                        ecsr_pkg::OP_BUILD: begin
                            n_out_v = 1'b0;
                            n_state = ecsr_pkg::S_CLEAR;
                        end
                        ecsr_pkg::OP_READ_OFF: begin
                            if (!r_valid) begin
                                n_out_status = ecsr_pkg::STAT_NOT_BUILT;
                            end else if (i_cmd.read_index > ecsr_pkg::IdxW'(nreg)) begin
                                n_out_status = ecsr_pkg::STAT_BAD_INDEX;
                            end else if (i_cmd.read_index == ecsr_pkg::IdxW'(nreg)) begin
                                n_out_value = ecsr_pkg::ValW'(r_placed);
                            end else begin
                                n_out_v   = 1'b0;
                                n_rd_slot = 1'b0;
                                n_state   = ecsr_pkg::S_READ;
                            end
                        end
                        ecsr_pkg::OP_READ_SLOT: begin
                            if (!r_valid) begin
                                n_out_status = ecsr_pkg::STAT_NOT_BUILT;
                            end else if ((i_cmd.read_index >= ecsr_pkg::IdxW'(r_placed)) ||
                                         (32'(i_cmd.read_index) >= ecsr_pkg::MaxEdges)) begin
                                n_out_status = ecsr_pkg::STAT_BAD_INDEX;
                            end else begin
                                n_out_v   = 1'b0;
                                n_rd_slot = 1'b1;
                                n_state   = ecsr_pkg::S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ecsr_pkg::S_READ: begin
                n_out_v      = 1'b1;
                n_out_status = ecsr_pkg::STAT_OK;
                n_out_value  = r_rd_slot ? ecsr_pkg::ValW'(q_ord) : ecsr_pkg::ValW'(q_offs);
                n_state      = ecsr_pkg::S_IDLE;
            end

            ecsr_pkg::S_CLEAR: begin
                cur_we    = 1'b1;
                cur_waddr = r_seq[ecsr_pkg::RegW-1:0];
                cur_wdata = '0;
                n_seq     = r_seq + 1'b1;
                if (r_seq == ecsr_pkg::SeqW'(ecsr_pkg::MaxRegions - 1)) begin
                    n_seq   = '0;
                    n_state = ecsr_pkg::S_COUNT;
                end
            end

            ecsr_pkg::S_COUNT, ecsr_pkg::S_SCATTER: begin
                issue  = r_seq < ecsr_pkg::SeqW'(r_edge_total);
                n_p1_v = issue;
                if (issue) begin
                    n_seq = r_seq + 1'b1;
                end
                n_p2_v = r_p1_v && (ecsr_pkg::RcW'(q_src) < nreg);
                if (r_p2_v) begin
                    cur_we    = 1'b1;
                    cur_wdata = cur + 1'b1;
                    n_fw_v    = 1'b1;
                    n_fw_data = cur + 1'b1;
                    ord_we    = (r_state == ecsr_pkg::S_SCATTER);
                end
                if (!issue && !r_p1_v && !r_p2_v) begin
                    n_seq = '0;
                    n_acc = '0;
                    if (r_state == ecsr_pkg::S_COUNT) begin
                        n_state = ecsr_pkg::S_PREFIX;
                    end else begin
                        n_valid      = 1'b1;
                        n_out_v      = 1'b1;
                        n_out_value  = '0;
                        n_out_status = ecsr_pkg::STAT_OK;
                        n_state      = ecsr_pkg::S_IDLE;
                    end
                end
            end

            ecsr_pkg::S_PREFIX: begin
                cur_raddr = r_seq[ecsr_pkg::RegW-1:0];
                issue     = r_seq < ecsr_pkg::SeqW'(nreg);
                n_p1_v    = issue;
                if (issue) begin
                    n_seq = r_seq + 1'b1;
                end
                if (r_p1_v) begin
                    offs_we   = 1'b1;
                    cur_we    = 1'b1;
                    cur_waddr = r_p1_reg;
                    cur_wdata = r_acc;
                    n_acc     = r_acc + q_cur;
                end
                if (!issue && !r_p1_v) begin
                    n_placed = r_acc;
                    n_seq    = '0;
                    n_state  = ecsr_pkg::S_SCATTER;
                end
            end

            default: begin
                n_state = ecsr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== test/tb_edge_list_to_csr_builder_top.sv =====
module tb_edge_list_to_csr_builder_top;
    import ecsr_pkg::*;

    typedef struct {
        logic [ValW-1:0] value;
        t_status         status;
    } t_csr_reply;

    class csr_scoreboard;
        logic [RcW-1:0]   region_count;
        logic [SrcW-1:0]  edge_src [MaxEdges];
        int               edge_count;
        logic [CntW-1:0]  row_off [MaxRegions+1];
        logic [EdgeW-1:0] order_slot [MaxEdges];
        bit               index_built;
        t_csr_reply       exp_q [$];
        int               errors;

        function new();
            region_count = RcW'(MaxRegions);
            edge_count   = 0;
            index_built  = 0;
            errors       = 0;
            for (int r = 0; r <= MaxRegions; r++) begin
                row_off[r] = '0;
            end
        endfunction

        function int active_regions();
            return (region_count > MaxRegions) ? MaxRegions : int'(region_count);
        endfunction

        function void note_cfg(logic [RcW-1:0] data);
            region_count = data;
            index_built  = 0;
        endfunction

        function void note_cmd(logic [OpW-1:0] op, logic [SrcW-1:0] src,
                               logic [IdxW-1:0] idx);
            t_csr_reply r;
            int nreg;
            int e;
            int s;
            int slot;
            int fill [MaxRegions];
            nreg     = active_regions();
            r.value  = '0;
            r.status = STAT_OK;
            case (op)
                OP_CLEAR: begin
                    edge_count  = 0;
                    index_built = 0;
                end
                OP_APPEND: begin
                    if (src >= nreg) begin
                        r.status = STAT_BAD_REGION;
                    end else if (edge_count >= MaxEdges) begin
                        r.status = STAT_FULL;
                    end else begin
                        edge_src[edge_count] = src;
                        edge_count++;
                        index_built = 0;
                    end
                end
                OP_BUILD: begin
                    for (s = 0; s <= MaxRegions; s++) begin
                        row_off[s] = '0;
                    end
                    for (s = 0; s < MaxRegions; s++) begin
                        fill[s] = 0;
                    end
                    for (e = 0; e < edge_count; e++) begin
                        s = edge_src[e];
                        if (s < nreg) begin
                            row_off[s+1] = row_off[s+1] + 1'b1;
                        end
                    end
                    for (s = 0; s < nreg; s++) begin
                        row_off[s+1] = row_off[s+1] + row_off[s];
                    end
                    for (e = 0; e < edge_count; e++) begin
                        s = edge_src[e];
                        if (s < nreg) begin
                            slot = int'(row_off[s]) + fill[s];
                            if (slot < MaxEdges) begin
                                order_slot[slot] = e[EdgeW-1:0];
                            end
                            fill[s]++;
                        end
                    end
                    index_built = 1;
                end
                OP_READ_OFF: begin
                    if (!index_built) begin
                        r.status = STAT_NOT_BUILT;
                    end else if (idx > nreg) begin
                        r.status = STAT_BAD_INDEX;
                    end else begin
                        r.value = row_off[idx];
                    end
                end
                OP_READ_SLOT: begin
                    if (!index_built) begin
                        r.status = STAT_NOT_BUILT;
                    end else if (idx >= row_off[nreg] || idx >= MaxEdges) begin
                        r.status = STAT_BAD_INDEX;
                    end else begin
                        r.value = ValW'(order_slot[idx]);
                    end
                end
                default: begin
                end
            endcase
            exp_q.push_back(r);
        endfunction

        function void check_rsp(logic [ValW-1:0] got_value, logic [StatW-1:0] got_status);
            t_csr_reply r;
            if (exp_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected result beat: value %0d status %0d",
                             got_value, got_status);
                end
            end else begin
                r = exp_q.pop_front();
                if (got_value !== r.value || got_status !== r.status) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Mismatch: expected value %0d status %0d, got value %0d status %0d",
                                 r.value, r.status, got_value, got_status);
                    end
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ecsr_in_if  cmd_if ();
    ecsr_out_if rsp_if ();
    ecsr_cfg_if cfg_if ();

    csr_scoreboard sb;
    int sent_total;
    int burst_left;

    edge_list_to_csr_builder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                sb.note_cfg(cfg_if.data);
            end
            if (cmd_if.valid && cmd_if.ready) begin
                sb.note_cmd(cmd_if.opcode, cmd_if.source_region, cmd_if.read_index);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_rsp(rsp_if.read_value, rsp_if.status);
            end
        end
    end

    initial begin
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase = (phase + 1) % 7;
            case (mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
                2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_if.ready <= (phase < 3);
            endcase
        end
    end

    task automatic send_cmd(input int op, input int src, input int idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        cmd_if.valid         <= 1'b1;
        cmd_if.opcode        <= op[OpW-1:0];
        cmd_if.source_region <= src[SrcW-1:0];
        cmd_if.read_index    <= idx[IdxW-1:0];
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sent_total++;
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_region_count(input logic [RcW-1:0] data);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input bit keep_edges, input int appends);
        int nreg;
        int reads;
        int placed;
        int k;
        write_region_count(count[RcW-1:0]);
        nreg = (count > MaxRegions) ? MaxRegions : count;
        send_cmd(OP_READ_OFF, $urandom_range(0, 255), $urandom_range(0, nreg));
        if (!keep_edges) begin
            send_cmd(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 2047));
        end
        for (k = 0; k < appends; k++) begin
            send_cmd(OP_APPEND,
                     ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, nreg - 1),
                     $urandom_range(0, 2047));
        end
        send_cmd(OP_BUILD, $urandom_range(0, 255), $urandom_range(0, 2047));
        reads = $urandom_range(15, 50);
        for (k = 0; k < reads; k++) begin
            placed = sb.row_off[nreg];
            case ($urandom_range(0, 19)) inside
                0: send_cmd($urandom_range(0, 7), $urandom_range(0, 255),
                            $urandom_range(0, 2047));
                1: send_cmd(OP_APPEND, $urandom_range(0, nreg - 1), $urandom_range(0, 2047));
                [2:8]: begin
                    send_cmd(OP_READ_OFF, $urandom_range(0, 255),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                         : $urandom_range(0, nreg + 1));
                end
                default: begin
                    send_cmd(OP_READ_SLOT, $urandom_range(0, 255),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                         : $urandom_range(0, placed));
                end
            endcase
        end
    endtask

    initial begin
        int k;
        int random_start;
        sb         = new();
        sent_total = 0;
        burst_left = 0;
        i_rst_n              <= 1'b0;
        cmd_if.valid         <= 1'b0;
        cmd_if.opcode        <= OP_CLEAR;
        cmd_if.source_region <= '0;
        cmd_if.read_index    <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.data          <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(OP_READ_OFF, 0, 0);
        send_cmd(OP_READ_SLOT, 0, 0);
        for (k = OP_READ_SLOT + 1; k < 2 ** OpW; k++) begin
            send_cmd(k, 8'hFF, 11'h7FF);
        end
        send_cmd(OP_APPEND, 0, 0);
        send_cmd(OP_APPEND, 255, 11'h7FF);
        send_cmd(OP_APPEND, 7, 0);
        send_cmd(OP_APPEND, 0, 0);
        send_cmd(OP_READ_OFF, 0, 0);
        send_cmd(OP_BUILD, 0, 0);
        send_cmd(OP_READ_OFF, 0, 0);
        send_cmd(OP_READ_OFF, 0, MaxRegions);
        send_cmd(OP_READ_OFF, 0, MaxRegions + 1);
        send_cmd(OP_READ_OFF, 0, 11'h7FF);
        send_cmd(OP_READ_SLOT, 0, 0);
        send_cmd(OP_READ_SLOT, 0, 3);
        send_cmd(OP_READ_SLOT, 0, 4);
        send_cmd(OP_READ_SLOT, 0, 11'h7FF);
        send_cmd(OP_APPEND, 3, 0);
        send_cmd(OP_READ_SLOT, 0, 0);
        send_cmd(OP_CLEAR, 0, 0);
        send_cmd(OP_BUILD, 0, 0);
        send_cmd(OP_READ_OFF, 0, MaxRegions);
        send_cmd(OP_READ_SLOT, 0, 0);

        random_start = sent_total;
        run_phase(1, 0, $urandom_range(5, 30));
        run_phase(MaxRegions, 0, $urandom_range(5, 40));
        run_phase(MaxRegions, 0, MaxEdges + 6);
        run_phase(2, 1, 0);
        run_phase(MaxRegions, 1, 3);
        while (sent_total - random_start < 800) begin
            run_phase($urandom_range(1, MaxRegions), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 40));
        end
        drain();

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
